FILE: hdl/sgit_pkg.sv
package sgit_pkg;

  localparam int MW = 16;
  localparam int SW = 15;
  localparam int GW = 16;
  localparam int PW = 2 * MW;
  localparam int AW = PW + 1;
  localparam int DETW = MW + AW + 2;
  localparam int NUMW = SW + AW + 2;
  localparam int NMW = NUMW + 14;
  localparam int DMW = DETW + 5;
  localparam int QBITS = 17;
  localparam int RW = DMW + QBITS;
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY = FRONT_STAGES + QBITS + 1;
  localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(32767);
  localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(32768);

endpackage

FILE: hdl/sgit_if.sv
interface sgit_req_if;
  logic valid;
  logic ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [14:0] strength_x, strength_y, strength_z;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 strength_x, strength_y, strength_z, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               strength_x, strength_y, strength_z, output ready);
endinterface

interface sgit_rsp_if;
  logic valid;
  logic ready;
  logic signed [15:0] grad_read, grad_phase, grad_slice;
  logic singular;
  modport source(output valid, grad_read, grad_phase, grad_slice, singular, input ready);
  modport sink(input valid, grad_read, grad_phase, grad_slice, singular, output ready);
endinterface

FILE: hdl/sgit_div.sv
module sgit_div (
  input  logic clk,
  input  logic en,
  input  logic [sgit_pkg::RW-1:0] n,
  input  logic [sgit_pkg::DMW-1:0] d,
  input  logic neg,
  output logic [sgit_pkg::QBITS-1:0] quo,
  output logic neg_out,
  output logic ovf_out
);
  import sgit_pkg::*;

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    localparam int K = QBITS - 1 - i;
    logic [RW-1:0]    rem_in;
    logic [DMW-1:0]   dvs_in;
    logic [QBITS-1:0] quot_in;
    logic             sgn_in;
    logic             ovf_in;
    logic [RW-1:0]    trial;
    logic             ge;
    logic [RW-1:0]    rem;
    logic [DMW-1:0]   dvs;
    logic [QBITS-1:0] quot;
    logic             sgn;
    logic             ovf;

    if (i == 0) begin : g_first
      assign rem_in = n;
      assign dvs_in = d;
      assign quot_in = '0;
      assign sgn_in = neg;
      assign ovf_in = (n >> QBITS) >= RW'(d);
    end else begin : g_next
      assign rem_in = g_step[i-1].rem;
      assign dvs_in = g_step[i-1].dvs;
      assign quot_in = g_step[i-1].quot;
      assign sgn_in = g_step[i-1].sgn;
      assign ovf_in = g_step[i-1].ovf;
    end

    assign trial = RW'(dvs_in) << K;
    assign ge = rem_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem <= ge ? rem_in - trial : rem_in;
        quot <= quot_in | (QBITS'(ge) << K);
        dvs <= dvs_in;
        sgn <= sgn_in;
        ovf <= ovf_in;
      end
    end
  end

  assign quo = g_step[QBITS-1].quot;
  assign neg_out = g_step[QBITS-1].sgn;
  assign ovf_out = g_step[QBITS-1].ovf;
endmodule

FILE: hdl/shim_gradient_inverse_transform.sv
// an input item passes the front end, the divider and an output register to become a result item
// throughput: one item per cycle, a 5-stage cofactor/product front end
// feeding a 17-stage restoring divider, one quotient bit per stage
// a stall on the result side holds the whole pipeline
// reset: synchronous, clears all valid bits; payload registers are not reset
module shim_gradient_inverse_transform (
  input logic clk,
  input logic rst,
  sgit_req_if.sink req,
  sgit_rsp_if.source rsp
);
  import sgit_pkg::*;

  logic en;
  logic [LATENCY-1:0] vld;

  logic signed [MW-1:0] a [3][3];
  logic signed [SW-1:0] s [3];

  logic signed [PW-1:0] pa [9];
  logic signed [PW-1:0] pb [9];
  logic signed [MW-1:0] r0_1 [3];
  logic signed [SW-1:0] s_1 [3];

  logic signed [AW-1:0] adj [9];
  logic signed [MW-1:0] r0_2 [3];
  logic signed [SW-1:0] s_2 [3];

  logic signed [DETW-1:0] dp [3];
  logic signed [NUMW-1:0] np [3][3];

  logic signed [DETW-1:0] det;
  logic signed [NUMW-1:0] num [3];

  logic [NUMW-1:0] nabs [3];
  logic [DETW-1:0] dabs;
  logic [RW-1:0] nsc [3];
  logic [DMW-1:0] dsc;
  logic neg5 [3];
  logic sing5;

  logic [QBITS-1:0] quo [3];
  logic qneg [3];
  logic qovf [3];
  logic [QBITS-1:0] sing_d;
  logic [GW-1:0] grad [3];

  assign en = !vld[LATENCY-1] || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = vld[LATENCY-1];

  assign a[0][0] = req.m00; assign a[0][1] = req.m01; assign a[0][2] = req.m02;
  assign a[1][0] = req.m10; assign a[1][1] = req.m11; assign a[1][2] = req.m12;
  assign a[2][0] = req.m20; assign a[2][1] = req.m21; assign a[2][2] = req.m22;
  assign s[0] = req.strength_x;
  assign s[1] = req.strength_y;
  assign s[2] = req.strength_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], req.valid};
    end
  end

  // cofactor products
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= a[1][1] * a[2][2]; pb[0] <= a[1][2] * a[2][1];
      pa[1] <= a[0][2] * a[2][1]; pb[1] <= a[0][1] * a[2][2];
      pa[2] <= a[0][1] * a[1][2]; pb[2] <= a[0][2] * a[1][1];
      pa[3] <= a[1][2] * a[2][0]; pb[3] <= a[1][0] * a[2][2];
      pa[4] <= a[0][0] * a[2][2]; pb[4] <= a[0][2] * a[2][0];
      pa[5] <= a[0][2] * a[1][0]; pb[5] <= a[0][0] * a[1][2];
      pa[6] <= a[1][0] * a[2][1]; pb[6] <= a[1][1] * a[2][0];
      pa[7] <= a[0][1] * a[2][0]; pb[7] <= a[0][0] * a[2][1];
      pa[8] <= a[0][0] * a[1][1]; pb[8] <= a[0][1] * a[1][0];
      for (int c = 0; c < 3; c++) begin
        r0_1[c] <= a[0][c];
        s_1[c] <= s[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        adj[k] <= AW'(pa[k]) - AW'(pb[k]);
      end
      r0_2 <= r0_1;
      s_2 <= s_1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dp[c] <= DETW'(r0_2[c] * adj[c*3]);
        for (int j = 0; j < 3; j++) begin
          np[c][j] <= NUMW'(s_2[c] * adj[c*3+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= dp[0] + dp[1] + dp[2];
      for (int j = 0; j < 3; j++) begin
        num[j] <= np[0][j] + np[1][j] + np[2][j];
      end
    end
  end

  // magnitudes, scale numerator by 12288 and denominator by 25
  always_comb begin
    dabs = det[DETW-1] ? -det : det;
    for (int j = 0; j < 3; j++) begin
      nabs[j] = num[j][NUMW-1] ? -num[j] : num[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsc <= (DMW'(dabs) << 4) + (DMW'(dabs) << 3) + DMW'(dabs);
      sing5 <= det == '0;
      for (int j = 0; j < 3; j++) begin
        nsc[j] <= (RW'(nabs[j]) << 13) + (RW'(nabs[j]) << 12);
        neg5[j] <= num[j][NUMW-1] ^ det[DETW-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    sgit_div u_div (
      .clk(clk), .en(en), .n(nsc[j]), .d(dsc), .neg(neg5[j]),
      .quo(quo[j]), .neg_out(qneg[j]), .ovf_out(qovf[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d <= {sing_d[QBITS-2:0], sing5};
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (qneg[j]) begin
        grad[j] = (qovf[j] || quo[j] > NEG_LIMIT) ? GW'(NEG_LIMIT) : GW'(-quo[j]);
      end else begin
        grad[j] = (qovf[j] || quo[j] > POS_LIMIT) ? GW'(POS_LIMIT) : GW'(quo[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.singular <= sing_d[QBITS-1];
      rsp.grad_read <= sing_d[QBITS-1] ? '0 : grad[0];
      rsp.grad_phase <= sing_d[QBITS-1] ? '0 : grad[1];
      rsp.grad_slice <= sing_d[QBITS-1] ? '0 : grad[2];
    end
  end
endmodule
